// ===== src/mcem_pkg.sv =====
// Package for the multichannel edge merge and trigger block.
// Holds the shared constants, register indexes and the sequencer state type.
// No dependencies.
package mcem_pkg;

   localparam int CHANNELS   = 16;
   localparam int TIME_BITS  = 64;
   localparam int CH_BITS    = $clog2(CHANNELS);
   localparam int CNT_BITS   = $clog2(CHANNELS + 1);
   localparam int COUNT_BITS = 5;
   localparam int CSR_BITS   = 16;
   localparam int IDX_BITS   = 2;

   typedef enum logic [IDX_BITS-1:0] {
      REG_ENABLED_MASK      = 2'd0,
      REG_INITIAL_LEVELS    = 2'd1,
      REG_RISE_TRIGGER_MASK = 2'd2,
      REG_FALL_TRIGGER_MASK = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   localparam logic ACT_SUPPLY  = 1'b0;
   localparam logic ACT_EXHAUST = 1'b1;

endpackage

// ===== src/mcem_time_ram.sv =====
// Simple dual-port RAM holding the pending transition time of each channel.
// One write port and one read port with registered read data. Depends on nothing.
module mcem_time_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/multichannel_edge_merge_trigger.sv =====
// Top level of the multichannel edge merge and trigger block.
// Depends on mcem_pkg and mcem_time_ram.
//
// Each item either supplies a channel's next transition time or marks the channel
// exhausted. The pending times live in a one-port-read RAM; the pending, exhausted and
// level bits live in flip-flops. After an item is taken the block checks whether a
// merge is due. If so it reads the sixteen pending times one per cycle and keeps
// the earliest time together with the mask of channels that share it, then emits
// one result and updates the levels. An item that causes a merge occupies the block
// through the accept, the check, the RAM scan and the emit; an item that causes no
// merge returns to idle after the check, and one that finds the stream finished goes
// from the check to the emit for a done result. The emit state is stretched for as
// long as the previous result has not been taken.
// The output is registered, so the next item is taken while a result still waits.
module multichannel_edge_merge_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [3:0]                          req_channel,
   input  logic [63:0]                         req_event_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [63:0]                         rsp_merged_time,
   output logic [15:0]                         rsp_toggled_channels,
   output logic [4:0]                          rsp_toggle_count,
   output logic [15:0]                         rsp_levels_after,
   output logic                                rsp_trigger_hit,
   output logic                                rsp_all_done,
   input  logic                                csr_write_enable,
   input  logic [mcem_pkg::IDX_BITS-1:0]       csr_index,
   input  logic [mcem_pkg::CSR_BITS-1:0]       csr_write_data
);

   import mcem_pkg::*;

   state_type state_ff, state_in;

   logic [CHANNELS-1:0] enabled_ff, rise_ff, fall_ff;
   logic [CHANNELS-1:0] levels_ff, levels_in;
   logic [CHANNELS-1:0] pending_ff, pending_in;
   logic [CHANNELS-1:0] exhausted_ff, exhausted_in;

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [CH_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                 have_ff, have_in;
   logic [TIME_BITS-1:0] best_time_ff, best_time_in;
   logic [CHANNELS-1:0]  best_mask_ff, best_mask_in;
   logic                 done_ff, done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_time_ff;
   logic [15:0]          rsp_mask_ff;
   logic [4:0]           rsp_count_ff;
   logic [15:0]          rsp_levels_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_done_ff;

   logic                 accept;
   logic                 ch_ok;
   logic [CHANNELS-1:0]  ch_bit;
   logic                 store_time;
   logic [CHANNELS-1:0]  live;
   logic [CHANNELS-1:0]  ready_mask;
   logic                 pop_due;
   logic                 finished;
   logic                 scan_issue;
   logic                 scan_last;
   logic                 rsp_free;
   logic                 rsp_load;
   logic [TIME_BITS-1:0] ram_rd_data;
   logic [CHANNELS-1:0]  new_levels;
   logic                 hit;

   // Item acceptance and its effect on the channel bits.
   assign accept     = req_valid && req_ready;
   assign ch_ok      = (32'(req_channel) < CHANNELS) && enabled_ff[req_channel[CH_BITS-1:0]];
   assign ch_bit     = CHANNELS'(1) << req_channel[CH_BITS-1:0];
   assign store_time = accept && ch_ok && (req_action == ACT_SUPPLY)
                       && !exhausted_ff[req_channel[CH_BITS-1:0]]
                       && !pending_ff[req_channel[CH_BITS-1:0]];

   assign live       = enabled_ff & ~exhausted_ff;
   assign ready_mask = pending_ff & enabled_ff;
   assign pop_due    = ((live & ~pending_ff) == '0) && (ready_mask != '0);
   assign finished   = (live == '0) && (ready_mask == '0);

   assign scan_issue = (state_ff == ST_SCAN) && (cnt_ff < CNT_BITS'(CHANNELS));
   assign scan_last  = rd_valid_ff && (rd_idx_ff == CH_BITS'(CHANNELS - 1));

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = (state_ff == ST_EMIT) && rsp_free;

   assign new_levels = levels_ff ^ best_mask_ff;
   assign hit        = ((best_mask_ff & new_levels & rise_ff)
                        | (best_mask_ff & levels_ff & fall_ff)) != '0;

   mcem_time_ram #(
      .DEPTH (CHANNELS),
      .WIDTH (TIME_BITS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (store_time),
      .wr_addr (req_channel[CH_BITS-1:0]),
      .wr_data (req_event_time[TIME_BITS-1:0]),
      .rd_en   (scan_issue),
      .rd_addr (cnt_ff[CH_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (pop_due) begin
               state_in = ST_SCAN;
            end else if (finished) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Datapath and bookkeeping updates.
   always_comb begin
      levels_in    = levels_ff;
      pending_in   = pending_ff;
      exhausted_in = exhausted_ff;
      cnt_in       = cnt_ff;
      rd_valid_in  = scan_issue;
      rd_idx_in    = cnt_ff[CH_BITS-1:0];
      have_in      = have_ff;
      best_time_in = best_time_ff;
      best_mask_in = best_mask_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept && ch_ok) begin
         if (req_action == ACT_EXHAUST) begin
            exhausted_in = exhausted_ff | ch_bit;
         end else if (store_time) begin
            pending_in = pending_ff | ch_bit;
         end
      end

      if (state_ff == ST_CHECK) begin
         cnt_in       = '0;
         have_in      = 1'b0;
         best_mask_in = '0;
         best_time_in = '0;
         done_in      = !pop_due;
      end

      if (scan_issue) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      // Keep the earliest time and gather every channel that shares it.
      if (rd_valid_ff && ready_mask[rd_idx_ff]) begin
         if (!have_ff || (ram_rd_data < best_time_ff)) begin
            have_in      = 1'b1;
            best_time_in = ram_rd_data;
            best_mask_in = CHANNELS'(1) << rd_idx_ff;
         end else if (ram_rd_data == best_time_ff) begin
            best_mask_in = best_mask_ff | (CHANNELS'(1) << rd_idx_ff);
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (!done_ff) begin
            levels_in  = new_levels;
            pending_in = pending_ff & ~best_mask_ff;
         end
      end

      if (csr_write_enable && (csr_index == REG_INITIAL_LEVELS)) begin
         levels_in = csr_write_data[CHANNELS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         levels_ff    <= '0;
         pending_ff   <= '0;
         exhausted_ff <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         levels_ff    <= levels_in;
         pending_ff   <= pending_in;
         exhausted_ff <= exhausted_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         have_ff      <= have_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_ENABLED_MASK:      enabled_ff <= csr_write_data[CHANNELS-1:0];
               REG_INITIAL_LEVELS:    ;
               REG_RISE_TRIGGER_MASK: rise_ff    <= csr_write_data[CHANNELS-1:0];
               REG_FALL_TRIGGER_MASK: fall_ff    <= csr_write_data[CHANNELS-1:0];
               default:               ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_time_ff <= best_time_in;
      best_mask_ff <= best_mask_in;
      if (rsp_load) begin
         if (done_ff) begin
            rsp_time_ff   <= '0;
            rsp_mask_ff   <= '0;
            rsp_count_ff  <= '0;
            rsp_levels_ff <= 16'(levels_ff);
            rsp_hit_ff    <= 1'b0;
            rsp_done_ff   <= 1'b1;
         end else begin
            rsp_time_ff   <= 64'(best_time_ff);
            rsp_mask_ff   <= 16'(best_mask_ff);
            rsp_count_ff  <= COUNT_BITS'($countones(best_mask_ff));
            rsp_levels_ff <= 16'(new_levels);
            rsp_hit_ff    <= hit;
            rsp_done_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_merged_time      = rsp_time_ff;
   assign rsp_toggled_channels = rsp_mask_ff;
   assign rsp_toggle_count     = rsp_count_ff;
   assign rsp_levels_after     = rsp_levels_ff;
   assign rsp_trigger_hit      = rsp_hit_ff;
   assign rsp_all_done         = rsp_done_ff;

`ifndef SYNTHESIS
   a_done_has_no_toggle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_mask_ff == '0 && !rsp_hit_ff))
      else $error("finished result carries a toggle");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |->
         (rsp_mask_ff != '0 && 32'(rsp_count_ff) == $countones(rsp_mask_ff)))
      else $error("merged result has a bad toggle mask or count");

   a_pop_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !done_ff) |=> ((pending_ff & $past(best_mask_ff)) == '0))
      else $error("popped channels still pending");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(CHANNELS))
      else $error("scan counter overran");
`endif

endmodule

// ===== tb/merge_checker.sv =====
// Checker for the multichannel edge merge and trigger block: watches the item, result
// and register ports, predicts every result and compares it field by field.
// Depends on mcem_pkg.
module merge_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_action,
   input  logic [3:0]                    req_channel,
   input  logic [63:0]                   req_event_time,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [63:0]                   rsp_merged_time,
   input  logic [15:0]                   rsp_toggled_channels,
   input  logic [4:0]                    rsp_toggle_count,
   input  logic [15:0]                   rsp_levels_after,
   input  logic                          rsp_trigger_hit,
   input  logic                          rsp_all_done,
   input  logic                          csr_write_enable,
   input  logic [mcem_pkg::IDX_BITS-1:0] csr_index,
   input  logic [mcem_pkg::CSR_BITS-1:0] csr_write_data,
   output int                            failures,
   output int                            open_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import mcem_pkg::*;

   typedef struct packed {
      logic [63:0] merged_time;
      logic [15:0] toggled_channels;
      logic [4:0]  toggle_count;
      logic [15:0] levels_after;
      logic        trigger_hit;
      logic        all_done;
   } merge_result_type;

   logic [15:0]      cfg_enable;
   logic [15:0]      cfg_rise;
   logic [15:0]      cfg_fall;
   logic [15:0]      held_valid;
   logic [63:0]      held_time [16];
   logic [15:0]      spent;
   logic [15:0]      level_now;
   merge_result_type expected_merges [$];
   merge_result_type want;

   // Applies one item to the predicted state and queues the result it causes, if any.
   task automatic predict_merge(input logic act, input logic [3:0] ch, input logic [63:0] t);
      logic [15:0]      live;
      logic [15:0]      rdy;
      logic [15:0]      tog;
      logic [15:0]      prev;
      logic [63:0]      best;
      logic             have;
      merge_result_type r;
      if (cfg_enable[ch]) begin
         if (act == ACT_EXHAUST) begin
            spent[ch] = 1'b1;
         end else if (!spent[ch] && !held_valid[ch]) begin
            held_time[ch]  = t;
            held_valid[ch] = 1'b1;
         end
      end
      live = cfg_enable & ~spent;
      rdy  = held_valid & cfg_enable;
      if ((live & ~held_valid) == 16'h0 && rdy != 16'h0) begin
         have = 1'b0;
         best = '0;
         for (int i = 0; i < 16; i++) begin
            if (rdy[i] && (!have || held_time[i] < best)) begin
               best = held_time[i];
               have = 1'b1;
            end
         end
         tog = '0;
         for (int i = 0; i < 16; i++) begin
            if (rdy[i] && held_time[i] == best) begin
               tog[i] = 1'b1;
            end
         end
         prev       = level_now;
         level_now  = prev ^ tog;
         held_valid = held_valid & ~tog;
         r.merged_time      = best;
         r.toggled_channels = tog;
         r.toggle_count     = 5'($countones(tog));
         r.levels_after     = level_now;
         r.trigger_hit      = |((tog & level_now & cfg_rise) | (tog & prev & cfg_fall));
         r.all_done         = 1'b0;
         expected_merges.push_back(r);
      end else if (live == 16'h0 && rdy == 16'h0) begin
         // Stream finished: every item earns a done result carrying the levels.
         r              = '0;
         r.levels_after = level_now;
         r.all_done     = 1'b1;
         expected_merges.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_enable       = '0;
         cfg_rise         = '0;
         cfg_fall         = '0;
         held_valid       = '0;
         spent            = '0;
         level_now        = '0;
         expected_merges.delete();
         failures         = 0;
         open_results     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_merges.size() == 0) begin
               $error("result arrived with no item awaiting one");
               failures++;
            end else begin
               want = expected_merges.pop_front();
               compare_field("merged_time", want.merged_time, rsp_merged_time);
               compare_field("toggled_channels", 64'(want.toggled_channels),
                             64'(rsp_toggled_channels));
               compare_field("toggle_count", 64'(want.toggle_count), 64'(rsp_toggle_count));
               compare_field("levels_after", 64'(want.levels_after), 64'(rsp_levels_after));
               compare_field("trigger_hit", 64'(want.trigger_hit), 64'(rsp_trigger_hit));
               compare_field("all_done", 64'(want.all_done), 64'(rsp_all_done));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_ENABLED_MASK: begin
                  cfg_enable = csr_write_data;
               end
               REG_INITIAL_LEVELS: begin
                  level_now = csr_write_data;
               end
               REG_RISE_TRIGGER_MASK: begin
                  cfg_rise = csr_write_data;
               end
               REG_FALL_TRIGGER_MASK: begin
                  cfg_fall = csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predict_merge(req_action, req_channel, req_event_time);
         end
         open_results = expected_merges.size();
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the multichannel edge merge and trigger block: makes the clock,
// reset, register writes, items and result stalls, and prints the verdict.
// Depends on mcem_pkg, merge_checker and multichannel_edge_merge_trigger.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcem_pkg::*;

   localparam int ITEM_TARGET = 1550;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [3:0]          req_channel;
   logic [63:0]         req_event_time;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [63:0]         rsp_merged_time;
   logic [15:0]         rsp_toggled_channels;
   logic [4:0]          rsp_toggle_count;
   logic [15:0]         rsp_levels_after;
   logic                rsp_trigger_hit;
   logic                rsp_all_done;
   logic                csr_write_enable;
   logic [IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0] csr_write_data;
   int                  failures;
   int                  open_results;

   // Rough view of the block kept only to steer the stimulus towards useful items.
   logic [15:0] en_seen = '0;
   logic [15:0] spent_seen = '0;
   logic [15:0] held_seen = '0;
   logic [63:0] last_time [16];
   int          items_sent = 0;
   logic        req_gaps_on = 1'b1;
   logic        rsp_stall_on = 1'b1;
   logic        hold_request = 1'b0;

   multichannel_edge_merge_trigger u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_channel          (req_channel),
      .req_event_time       (req_event_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_merged_time      (rsp_merged_time),
      .rsp_toggled_channels (rsp_toggled_channels),
      .rsp_toggle_count     (rsp_toggle_count),
      .rsp_levels_after     (rsp_levels_after),
      .rsp_trigger_hit      (rsp_trigger_hit),
      .rsp_all_done         (rsp_all_done),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   merge_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_channel          (req_channel),
      .req_event_time       (req_event_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_merged_time      (rsp_merged_time),
      .rsp_toggled_channels (rsp_toggled_channels),
      .rsp_toggle_count     (rsp_toggle_count),
      .rsp_levels_after     (rsp_levels_after),
      .rsp_trigger_hit      (rsp_trigger_hit),
      .rsp_all_done         (rsp_all_done),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .failures             (failures),
      .open_results         (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(input logic act, input logic [3:0] ch, input logic [63:0] t);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_channel    <= ch;
      req_event_time <= t;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (en_seen[ch]) begin
         if (act == ACT_EXHAUST) begin
            spent_seen[ch] = 1'b1;
         end else if (!spent_seen[ch] && !held_seen[ch]) begin
            held_seen[ch] = 1'b1;
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == REG_ENABLED_MASK) begin
         en_seen = value;
      end
   endtask

   task automatic program_regs(input logic [3:0] which, input logic [15:0] en_v,
                               input logic [15:0] lv_v, input logic [15:0] ri_v,
                               input logic [15:0] fa_v);
      if (which[0]) write_reg(REG_ENABLED_MASK, en_v);
      if (which[1]) write_reg(REG_INITIAL_LEVELS, lv_v);
      if (which[2]) write_reg(REG_RISE_TRIGGER_MASK, ri_v);
      if (which[3]) write_reg(REG_FALL_TRIGGER_MASK, fa_v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Registers may only change once the block has delivered everything and settled.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_mask();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001 << $urandom_range(0, 15);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls per item, plus an occasional long hold-off.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            stall        = 300;
            hold_request = 1'b0;
         end else begin
            stall = rsp_stall_on ? $urandom_range(0, 17) : 0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         held_seen = held_seen & ~rsp_toggled_channels;
      end
   end

   initial begin
      logic [15:0] need;
      logic [15:0] en_v;
      logic [63:0] base;
      logic [63:0] t;
      logic [3:0]  ch;
      logic        act;
      int          n;
      int          phase;
      int          tmp;
      int          order [16];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_SUPPLY;
      req_channel      = '0;
      req_event_time   = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_ENABLED_MASK;
      csr_write_data   = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Channel 15 holds the earliest time when it is exhausted, so after its pop the
      // other channels are all waiting and the next pop needs a further item.
      program_regs(4'hF, 16'h8003, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_item(ACT_SUPPLY, 4'd15, 64'd5);
      send_item(ACT_SUPPLY, 4'd0, 64'd10);
      send_item(ACT_SUPPLY, 4'd0, 64'd3);
      send_item(ACT_SUPPLY, 4'd4, 64'd1);
      send_item(ACT_EXHAUST, 4'd15, 64'd0);
      send_item(ACT_SUPPLY, 4'd15, 64'd0);
      send_item(ACT_SUPPLY, 4'd1, 64'd10);
      send_item(ACT_SUPPLY, 4'd7, 64'd0);
      send_item(ACT_SUPPLY, 4'd0, '1);
      send_item(ACT_SUPPLY, 4'd1, 64'd0);
      send_item(ACT_SUPPLY, 4'd1, '1);
      send_item(ACT_SUPPLY, 4'd0, 64'd2);
      send_item(ACT_SUPPLY, 4'd1, 64'd2);
      wait_idle();
      program_regs(4'hF, 16'h0003, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(ACT_SUPPLY, 4'd0, 64'h8000_0000_0000_0000);
      send_item(ACT_SUPPLY, 4'd1, 64'h7FFF_FFFF_FFFF_FFFF);
      // Only the exhausted channel left enabled: channel 0 keeps its time while disabled.
      wait_idle();
      program_regs(4'b0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_item(ACT_SUPPLY, 4'd15, 64'd1);
      send_item(ACT_EXHAUST, 4'd3, 64'd0);
      wait_idle();
      program_regs(4'b0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(ACT_SUPPLY, 4'd9, '1);

      phase = 0;
      // Leave room for the last phase and the wind-down items.
      while (items_sent < ITEM_TARGET - 120) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0: en_v = 16'h0000;
            1, 2: en_v = 16'hFFFF;
            3: en_v = 16'h0001 << $urandom_range(0, 15);
            default: en_v = 16'($urandom | $urandom);
         endcase
         program_regs(phase == 0 ? 4'hF : 4'($urandom), en_v, pick_mask(), pick_mask(),
                      pick_mask());
         case ($urandom_range(0, 3))
            0: base = '0;
            1: base = 64'hFFFF_FFFF_FFFF_FFC0;
            default: base = {$urandom, $urandom};
         endcase
         foreach (last_time[i]) last_time[i] = base;
         req_gaps_on  = ($urandom_range(0, 2) != 0);
         rsp_stall_on = ($urandom_range(0, 2) != 0);
         n = $urandom_range(30, 120);
         for (int k = 0; k < n; k++) begin
            if (k == n / 2 && phase % 4 == 1) begin
               hold_request = 1'b1;
            end
            need = en_seen & ~spent_seen & ~held_seen;
            if (need != 16'h0 && $urandom_range(0, 9) != 0) begin
               do ch = 4'($urandom_range(0, 15)); while (!need[ch]);
               if ($countones(~spent_seen) > 4 && $urandom_range(0, 149) == 0) begin
                  act = ACT_EXHAUST;
                  t   = {$urandom, $urandom};
               end else begin
                  act = ACT_SUPPLY;
                  if ($urandom_range(0, 15) == 0) begin
                     t = {$urandom, $urandom};
                  end else begin
                     t = last_time[ch] + 64'($urandom_range(0, 3));
                  end
                  last_time[ch] = t;
               end
            end else begin
               // Noise: usually ignored by the block, but it also drains a waiting pop.
               ch  = 4'($urandom_range(0, 15));
               t   = {$urandom, $urandom};
               act = (!en_seen[ch] && $urandom_range(0, 1)) ? ACT_EXHAUST : ACT_SUPPLY;
            end
            send_item(act, ch, t);
         end
         phase++;
      end

      // Wind down: exhaust every channel, then drain the held times and reach done.
      wait_idle();
      program_regs(4'b0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      foreach (order[i]) order[i] = i;
      for (int j = 15; j > 0; j--) begin
         tmp          = $urandom_range(0, j);
         n            = order[j];
         order[j]     = order[tmp];
         order[tmp]   = n;
      end
      foreach (order[i]) send_item(ACT_EXHAUST, 4'(order[i]), {$urandom, $urandom});
      repeat (20) send_item(ACT_SUPPLY, 4'($urandom_range(0, 15)), {$urandom, $urandom});
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
